>>> hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Expression must hold on every cycle outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");

`endif

>>> hw/rtl/gkmst_pkg.sv
// Shared types and register index codes of the grid spanning tree builder.
package gkmst_pkg;

   typedef struct packed {
      logic [7:0] c2;
      logic [7:0] c1;
      logic [7:0] c0;
   } pixel_type;

   localparam logic [1:0] CSR_IMAGE_WIDTH       = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT      = 2'd1;
   localparam logic [1:0] CSR_COLOR_MODE        = 2'd2;
   localparam logic [1:0] CSR_SEGMENT_THRESHOLD = 2'd3;

   localparam int CHANNELS = 3;

endpackage

>>> hw/rtl/grid_kruskal_mst_builder_top.sv
// Top level of the grid minimum spanning tree builder.
// Pixels load one per cycle while idle, in row-major order; the request that completes the
// frame starts a build during which req_ready is low. A frame of N = width*height nodes has
// E = 2N-width-height edges. The build clears the bucket and parent memories, weighs and
// buckets the edges, forms the bucket prefix sums, sorts the edges by weight and takes them in
// that order; each root search of an edge end follows parent links, one parent memory read and
// one check per step. A read request passes a tree list read, an edge memory read and the
// result register, or goes straight to the result register when no edge is left. All frame
// data sits in single-port-write memories with registered reads; accesses to one entry never
// overlap because the sequencer finishes each read-modify-write before the next step starts.
module grid_kruskal_mst_builder_top #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int LEVELS     = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_pixel_c0,
   input  logic [7:0]  req_pixel_c1,
   input  logic [7:0]  req_pixel_c2,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_node_a,
   output logic [11:0] rsp_node_b,
   output logic [7:0]  rsp_weight,
   output logic        rsp_cut,
   output logic        rsp_exhausted,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import gkmst_pkg::*;

   `include "assert_macros.svh"

   localparam int NODES = MAX_WIDTH * MAX_HEIGHT;
   localparam int EDGES = MAX_HEIGHT * (MAX_WIDTH - 1) + MAX_WIDTH * (MAX_HEIGHT - 1);
   localparam int NW    = $clog2(NODES);
   localparam int EW    = $clog2(EDGES);
   localparam int LW    = $clog2(LEVELS);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int DW    = (WW > HW) ? WW : HW;
   localparam int MAXI  = (LEVELS > NODES) ? LEVELS : NODES;
   localparam int MAXC  = (EDGES > LEVELS) ? EDGES : LEVELS;
   localparam int CW    = $clog2(MAXC + 1);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_INIT  = 5'd1;
   localparam logic [4:0] ST_W_RD  = 5'd2;
   localparam logic [4:0] ST_W_CMP = 5'd3;
   localparam logic [4:0] ST_W_BKT = 5'd4;
   localparam logic [4:0] ST_P_RD  = 5'd5;
   localparam logic [4:0] ST_P_WR  = 5'd6;
   localparam logic [4:0] ST_S_RD  = 5'd7;
   localparam logic [4:0] ST_S_BRD = 5'd8;
   localparam logic [4:0] ST_S_WR  = 5'd9;
   localparam logic [4:0] ST_K_RD  = 5'd10;
   localparam logic [4:0] ST_K_EDG = 5'd11;
   localparam logic [4:0] ST_K_AB  = 5'd12;
   localparam logic [4:0] ST_K_FRD = 5'd13;
   localparam logic [4:0] ST_K_FCK = 5'd14;
   localparam logic [4:0] ST_K_UNI = 5'd15;
   localparam logic [4:0] ST_R_TRD = 5'd16;
   localparam logic [4:0] ST_R_ERD = 5'd17;
   localparam logic [4:0] ST_R_OUT = 5'd18;

   // configuration
   logic [6:0] width_ff, height_ff;
   logic       color_ff;
   logic [8:0] thr_ff;

   // memories
   pixel_type         pix_mem [NODES];
   logic [NW+7:0]     edge_mem [EDGES];
   logic [EW:0]       bkt_mem [LEVELS];
   logic [EW-1:0]     srt_mem [EDGES];
   logic [NW-1:0]     par_mem [NODES];
   logic [EW:0]       tre_mem [NODES];

   pixel_type     pix_rd0_ff, pix_rd1_ff, pix_wd;
   logic          pix_we;
   logic [NW-1:0] pix_wa, pix_ra0, pix_ra1;
   logic [NW+7:0] edge_rd_ff, edge_wd;
   logic          edge_we;
   logic [EW-1:0] edge_wa, edge_ra;
   logic [EW:0]   bkt_rd_ff, bkt_wd;
   logic          bkt_we;
   logic [LW-1:0] bkt_wa, bkt_ra;
   logic [EW-1:0] srt_rd_ff, srt_wd, srt_wa, srt_ra;
   logic          srt_we;
   logic [NW-1:0] par_rd_ff, par_wd, par_wa, par_ra;
   logic          par_we;
   logic [EW:0]   tre_rd_ff, tre_wd;
   logic          tre_we;
   logic [NW-1:0] tre_wa, tre_ra;

   // control
   logic [4:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW:0]   pcnt_ff, pcnt_in, tcnt_ff, tcnt_in, rptr_ff, rptr_in;
   logic          built_ff, built_in;
   logic [WW-1:0] w_ff, w_in;
   logic [HW-1:0] h_ff, h_in;
   logic [NW:0]   nodes_ff, nodes_in;
   logic [EW:0]   nh_ff, nh_in, edges_ff, edges_in, sum_ff, sum_in;
   logic [NW-1:0] wa_ff, wa_in, node_ff, node_in, nb_ff, nb_in, ra_ff, ra_in;
   logic [DW-1:0] cx_ff, cx_in;
   logic [WW-1:0] col_ff, col_in;
   logic [EW-1:0] e_ff, e_in;
   logic [7:0]    wt_ff, wt_in;
   logic          side_ff, side_in, cut_ff, cut_in, exh_ff, exh_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [11:0]   rsp_node_a_ff, rsp_node_a_in, rsp_node_b_ff, rsp_node_b_in;
   logic [7:0]    rsp_weight_ff, rsp_weight_in;
   logic          rsp_cut_ff, rsp_cut_in, rsp_exh_ff, rsp_exh_in;

   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [NW:0]   nodes_eff;
   logic [7:0]    wt_raw, wt_sat;
   logic          vert, req_take;
   logic [NW-1:0] wb, load_idx, edge_a;
   pixel_type     req_pix;

   assign w_eff = (width_ff < 7'd2) ? WW'(2) :
                  (32'(width_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_ff);
   assign h_eff = (height_ff < 7'd2) ? HW'(2) :
                  (32'(height_ff) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_ff);
   assign nodes_eff = (NW + 1)'(32'(w_eff) * 32'(h_eff));

   assign vert   = 32'(cnt_ff) >= 32'(nh_ff);
   assign wb     = vert ? NW'(32'(wa_ff) + 32'(w_ff)) : NW'(32'(wa_ff) + 1);
   assign edge_a = edge_rd_ff[NW+7:8];
   assign wt_sat = (32'(wt_raw) > LEVELS - 1) ? 8'(LEVELS - 1) : wt_raw;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign load_idx  = built_ff ? '0 : NW'(pcnt_ff);
   assign req_pix   = '{c2: req_pixel_c2, c1: req_pixel_c1, c0: req_pixel_c0};

   gkmst_edge_weight u_weight (
      .pix_a      (pix_rd0_ff),
      .pix_b      (pix_rd1_ff),
      .color_mode (color_ff),
      .weight     (wt_raw)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pcnt_in       = pcnt_ff;
      tcnt_in       = tcnt_ff;
      rptr_in       = rptr_ff;
      built_in      = built_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      nodes_in      = nodes_ff;
      nh_in         = nh_ff;
      edges_in      = edges_ff;
      sum_in        = sum_ff;
      wa_in         = wa_ff;
      node_in       = node_ff;
      nb_in         = nb_ff;
      ra_in         = ra_ff;
      cx_in         = cx_ff;
      col_in        = col_ff;
      e_in          = e_ff;
      wt_in         = wt_ff;
      side_in       = side_ff;
      cut_in        = cut_ff;
      exh_in        = exh_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_node_a_in = rsp_node_a_ff;
      rsp_node_b_in = rsp_node_b_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_cut_in    = rsp_cut_ff;
      rsp_exh_in    = rsp_exh_ff;

      pix_we  = 1'b0;
      pix_wa  = load_idx;
      pix_wd  = req_pix;
      pix_ra0 = wa_ff;
      pix_ra1 = wb;
      edge_we = 1'b0;
      edge_wa = cnt_ff[EW-1:0];
      edge_wd = {wa_ff, wt_sat};
      edge_ra = e_ff;
      bkt_we  = 1'b0;
      bkt_wa  = LW'(wt_ff);
      bkt_wd  = bkt_rd_ff + 1'b1;
      bkt_ra  = LW'(wt_ff);
      srt_we  = 1'b0;
      srt_wa  = bkt_rd_ff[EW-1:0];
      srt_wd  = cnt_ff[EW-1:0];
      srt_ra  = cnt_ff[EW-1:0];
      par_we  = 1'b0;
      par_wa  = ra_ff;
      par_wd  = node_ff;
      par_ra  = node_ff;
      tre_we  = 1'b0;
      tre_wa  = tcnt_ff[NW-1:0];
      tre_wd  = {e_ff, cut_ff};
      tre_ra  = rptr_ff[NW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_take && !req_mode) begin
               if (built_ff) begin
                  tcnt_in = '0;
                  rptr_in = '0;
               end
               built_in = 1'b0;
               pcnt_in  = (NW + 1)'(load_idx);
               if (32'(load_idx) < NODES) begin
                  pix_we  = 1'b1;
                  pcnt_in = (NW + 1)'(32'(load_idx) + 1);
               end
               if (pcnt_in >= nodes_eff) begin
                  w_in     = w_eff;
                  h_in     = h_eff;
                  nodes_in = nodes_eff;
                  nh_in    = (EW + 1)'(32'(nodes_eff) - 32'(h_eff));
                  edges_in = (EW + 1)'(2 * 32'(nodes_eff) - 32'(w_eff) - 32'(h_eff));
                  cnt_in   = '0;
                  state_in = ST_INIT;
               end
            end else if (req_take) begin
               if (!built_ff || rptr_ff >= tcnt_ff) begin
                  exh_in   = 1'b1;
                  state_in = ST_R_OUT;
               end else begin
                  exh_in   = 1'b0;
                  state_in = ST_R_TRD;
               end
            end
         end
         ST_INIT: begin
            bkt_wa = cnt_ff[LW-1:0];
            bkt_wd = '0;
            bkt_we = 32'(cnt_ff) < LEVELS;
            par_wa = cnt_ff[NW-1:0];
            par_wd = cnt_ff[NW-1:0];
            par_we = 32'(cnt_ff) < NODES;
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == MAXI - 1) begin
               cnt_in   = '0;
               wa_in    = '0;
               cx_in    = '0;
               col_in   = '0;
               tcnt_in  = '0;
               state_in = ST_W_RD;
            end
         end
         ST_W_RD: begin
            state_in = ST_W_CMP;
         end
         ST_W_CMP: begin
            edge_we  = 1'b1;
            wt_in    = wt_sat;
            bkt_ra   = LW'(wt_sat);
            state_in = ST_W_BKT;
         end
         ST_W_BKT: begin
            bkt_we = 1'b1;
            if (!vert) begin
               if (32'(cnt_ff) + 1 == 32'(nh_ff)) begin
                  wa_in  = '0;
                  cx_in  = '0;
                  col_in = '0;
               end else if (32'(cx_ff) == 32'(w_ff) - 2) begin
                  cx_in = '0;
                  wa_in = NW'(32'(wa_ff) + 2);
               end else begin
                  cx_in = cx_ff + 1'b1;
                  wa_in = wa_ff + 1'b1;
               end
            end else begin
               if (32'(cx_ff) == 32'(h_ff) - 2) begin
                  cx_in  = '0;
                  col_in = col_ff + 1'b1;
                  wa_in  = NW'(32'(col_ff) + 1);
               end else begin
                  cx_in = cx_ff + 1'b1;
                  wa_in = NW'(32'(wa_ff) + 32'(w_ff));
               end
            end
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_W_RD;
            if (32'(cnt_ff) == 32'(edges_ff) - 1) begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_P_RD;
            end
         end
         ST_P_RD: begin
            bkt_ra   = cnt_ff[LW-1:0];
            state_in = ST_P_WR;
         end
         ST_P_WR: begin
            bkt_we   = 1'b1;
            bkt_wa   = cnt_ff[LW-1:0];
            bkt_wd   = sum_ff;
            sum_in   = sum_ff + bkt_rd_ff;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_P_RD;
            if (32'(cnt_ff) == LEVELS - 1) begin
               cnt_in   = '0;
               state_in = ST_S_RD;
            end
         end
         ST_S_RD: begin
            edge_ra  = cnt_ff[EW-1:0];
            state_in = ST_S_BRD;
         end
         ST_S_BRD: begin
            wt_in    = edge_rd_ff[7:0];
            bkt_ra   = LW'(edge_rd_ff[7:0]);
            state_in = ST_S_WR;
         end
         ST_S_WR: begin
            srt_we   = 1'b1;
            bkt_we   = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_S_RD;
            if (32'(cnt_ff) == 32'(edges_ff) - 1) begin
               cnt_in   = '0;
               state_in = ST_K_RD;
            end
         end
         ST_K_RD: begin
            state_in = ST_K_EDG;
         end
         ST_K_EDG: begin
            e_in     = srt_rd_ff;
            edge_ra  = srt_rd_ff;
            state_in = ST_K_AB;
         end
         ST_K_AB: begin
            wt_in    = edge_rd_ff[7:0];
            cut_in   = {1'b0, edge_rd_ff[7:0]} >= thr_ff;
            node_in  = edge_a;
            nb_in    = (32'(e_ff) >= 32'(nh_ff)) ? NW'(32'(edge_a) + 32'(w_ff))
                                                 : NW'(32'(edge_a) + 1);
            side_in  = 1'b0;
            state_in = ST_K_FRD;
         end
         ST_K_FRD: begin
            state_in = ST_K_FCK;
         end
         ST_K_FCK: begin
            state_in = ST_K_FRD;
            if (par_rd_ff == node_ff) begin
               if (!side_ff) begin
                  ra_in   = node_ff;
                  node_in = nb_ff;
                  side_in = 1'b1;
               end else begin
                  state_in = ST_K_UNI;
               end
            end else begin
               node_in = par_rd_ff;
            end
         end
         ST_K_UNI: begin
            if (ra_ff != node_ff) begin
               par_we = 1'b1;
               if (32'(tcnt_ff) < NODES) begin
                  tre_we  = 1'b1;
                  tcnt_in = tcnt_ff + 1'b1;
               end
            end
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_K_RD;
            if (32'(cnt_ff) == 32'(edges_ff) - 1) begin
               cnt_in   = '0;
               rptr_in  = '0;
               built_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_R_TRD: begin
            state_in = ST_R_ERD;
         end
         ST_R_ERD: begin
            e_in     = tre_rd_ff[EW:1];
            cut_in   = tre_rd_ff[0];
            edge_ra  = tre_rd_ff[EW:1];
            state_in = ST_R_OUT;
         end
         ST_R_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_exh_in   = exh_ff;
               if (exh_ff) begin
                  rsp_node_a_in = '0;
                  rsp_node_b_in = '0;
                  rsp_weight_in = '0;
                  rsp_cut_in    = 1'b0;
               end else begin
                  rsp_node_a_in = 12'(edge_a);
                  rsp_node_b_in = (32'(e_ff) >= 32'(nh_ff)) ? 12'(32'(edge_a) + 32'(w_ff))
                                                            : 12'(32'(edge_a) + 1);
                  rsp_weight_in = edge_rd_ff[7:0];
                  rsp_cut_in    = cut_ff;
                  rptr_in       = rptr_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pcnt_ff      <= '0;
         tcnt_ff      <= '0;
         rptr_ff      <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= 7'd64;
         height_ff    <= 7'd64;
         color_ff     <= 1'b0;
         thr_ff       <= 9'd256;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pcnt_ff      <= pcnt_in;
         tcnt_ff      <= tcnt_in;
         rptr_ff      <= rptr_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:       width_ff  <= csr_wdata[6:0];
               CSR_IMAGE_HEIGHT:      height_ff <= csr_wdata[6:0];
               CSR_COLOR_MODE:        color_ff  <= csr_wdata[0];
               CSR_SEGMENT_THRESHOLD: thr_ff    <= csr_wdata;
               default:               thr_ff    <= thr_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff          <= w_in;
      h_ff          <= h_in;
      nodes_ff      <= nodes_in;
      nh_ff         <= nh_in;
      edges_ff      <= edges_in;
      sum_ff        <= sum_in;
      wa_ff         <= wa_in;
      node_ff       <= node_in;
      nb_ff         <= nb_in;
      ra_ff         <= ra_in;
      cx_ff         <= cx_in;
      col_ff        <= col_in;
      e_ff          <= e_in;
      wt_ff         <= wt_in;
      side_ff       <= side_in;
      cut_ff        <= cut_in;
      exh_ff        <= exh_in;
      rsp_node_a_ff <= rsp_node_a_in;
      rsp_node_b_ff <= rsp_node_b_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_cut_ff    <= rsp_cut_in;
      rsp_exh_ff    <= rsp_exh_in;
   end

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[pix_wa] <= pix_wd;
      end
      pix_rd0_ff <= pix_mem[pix_ra0];
      pix_rd1_ff <= pix_mem[pix_ra1];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      edge_rd_ff <= edge_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_wa] <= bkt_wd;
      end
      bkt_rd_ff <= bkt_mem[bkt_ra];
   end

   always_ff @(posedge clock) begin
      if (srt_we) begin
         srt_mem[srt_wa] <= srt_wd;
      end
      srt_rd_ff <= srt_mem[srt_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[par_wa] <= par_wd;
      end
      par_rd_ff <= par_mem[par_ra];
   end

   always_ff @(posedge clock) begin
      if (tre_we) begin
         tre_mem[tre_wa] <= tre_wd;
      end
      tre_rd_ff <= tre_mem[tre_ra];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_node_a    = rsp_node_a_ff;
   assign rsp_node_b    = rsp_node_b_ff;
   assign rsp_weight    = rsp_weight_ff;
   assign rsp_cut       = rsp_cut_ff;
   assign rsp_exhausted = rsp_exh_ff;

   `ASSERT_IMPLIES(a_tree_size, clock, reset, built_ff, 32'(tcnt_ff) == 32'(nodes_ff) - 1)
   `ASSERT_ALWAYS(a_rptr_bound, clock, reset, rptr_ff <= tcnt_ff)
   `ASSERT_IMPLIES(a_union_edge, clock, reset, state_ff == ST_K_UNI, 32'(cnt_ff) < 32'(edges_ff))

endmodule

>>> hw/rtl/gkmst_edge_weight.sv
// Edge weight: channel zero difference, or largest channel difference in color mode.
module gkmst_edge_weight (
   input  gkmst_pkg::pixel_type pix_a,
   input  gkmst_pkg::pixel_type pix_b,
   input  logic                 color_mode,
   output logic [7:0]           weight
);
   import gkmst_pkg::*;

   logic [CHANNELS-1:0][7:0] diff;
   logic [7:0] va [CHANNELS];
   logic [7:0] vb [CHANNELS];

   assign va[0] = pix_a.c0;
   assign va[1] = pix_a.c1;
   assign va[2] = pix_a.c2;
   assign vb[0] = pix_b.c0;
   assign vb[1] = pix_b.c1;
   assign vb[2] = pix_b.c2;

   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         diff[k] = (va[k] > vb[k]) ? (va[k] - vb[k]) : (vb[k] - va[k]);
      end
      weight = diff[0];
      if (color_mode) begin
         for (int k = 1; k < CHANNELS; k++) begin
            if (diff[k] > weight) begin
               weight = diff[k];
            end
         end
      end
   end

endmodule

>>> tb/sv/grid_kruskal_mst_builder_top_tb.sv
// Self-checking testbench for the grid spanning tree builder: directed table, then random frames.
module grid_kruskal_mst_builder_top_tb;
   import gkmst_pkg::*;

   localparam int MAX_NODES   = 4096;
   localparam int MAX_EDGES   = 8064;
   localparam int RANDOM_GOAL = 1150;
   localparam int STALL_LIMIT = 400000;

   typedef enum logic [1:0] {STEP_LOAD, STEP_READ, STEP_CSR} step_kind_type;

   typedef struct packed {
      logic [11:0] node_a;
      logic [11:0] node_b;
      logic [7:0]  weight;
      logic        cut;
      logic        exhausted;
   } tree_edge_type;

   typedef struct {
      step_kind_type kind;
      int            a;
      int            b;
      int            c;
      bit            typed;
      tree_edge_type typed_edge;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [7:0]  req_pixel_c0;
   logic [7:0]  req_pixel_c1;
   logic [7:0]  req_pixel_c2;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_node_a;
   logic [11:0] rsp_node_b;
   logic [7:0]  rsp_weight;
   logic        rsp_cut;
   logic        rsp_exhausted;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [8:0]  csr_wdata;

   // predictor state
   logic [6:0]  mdl_width;
   logic [6:0]  mdl_height;
   logic        mdl_color;
   logic [8:0]  mdl_threshold;
   pixel_type   mdl_pixels [MAX_NODES];
   logic [7:0]  mdl_weights [MAX_EDGES];
   int          mdl_sorted [MAX_EDGES];
   int          mdl_parent [MAX_NODES];
   logic [13:0] mdl_tree [MAX_NODES];
   int          mdl_pixel_count;
   int          mdl_tree_count;
   int          mdl_read_ptr;
   bit          mdl_built;
   int          mdl_built_w;
   int          mdl_built_h;

   tree_edge_type edges_due [$];
   stim_row_type  directed [$];
   int          fail_count = 0;
   int          accepted_count;
   int          random_count;
   int          frame_count;
   int          read_count;
   int          stall_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;

   grid_kruskal_mst_builder_top dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int clamp_size(logic [6:0] v);
      if (v < 2) return 2;
      if (v > 64) return 64;
      return int'(v);
   endfunction

   function automatic void edge_ends(int e, int w, int h, output int a, output int b);
      int nh;
      nh = h * (w - 1);
      if (e < nh) begin
         a = (e / (w - 1)) * w + e % (w - 1);
         b = a + 1;
      end else begin
         a = ((e - nh) % (h - 1)) * w + (e - nh) / (h - 1);
         b = a + w;
      end
   endfunction

   function automatic logic [7:0] chan_diff(logic [7:0] x, logic [7:0] y);
      return (x > y) ? x - y : y - x;
   endfunction

   function automatic int find_root(int n);
      int r;
      int t;
      r = n;
      while (mdl_parent[r] != r) r = mdl_parent[r];
      while (mdl_parent[n] != r) begin
         t = mdl_parent[n];
         mdl_parent[n] = r;
         n = t;
      end
      return r;
   endfunction

   function automatic void predict_build();
      int w, h, nodes, edges, a, b, ra, rb, sum, cnt, pos;
      int bucket [256];
      logic [7:0] wt, d;
      w = clamp_size(mdl_width);
      h = clamp_size(mdl_height);
      nodes = w * h;
      edges = h * (w - 1) + w * (h - 1);
      for (int e = 0; e < edges; e++) begin
         edge_ends(e, w, h, a, b);
         wt = chan_diff(mdl_pixels[a].c0, mdl_pixels[b].c0);
         if (mdl_color) begin
            d = chan_diff(mdl_pixels[a].c1, mdl_pixels[b].c1);
            if (d > wt) wt = d;
            d = chan_diff(mdl_pixels[a].c2, mdl_pixels[b].c2);
            if (d > wt) wt = d;
         end
         mdl_weights[e] = wt;
      end
      for (int i = 0; i < 256; i++) bucket[i] = 0;
      for (int e = 0; e < edges; e++) bucket[mdl_weights[e]]++;
      sum = 0;
      for (int i = 0; i < 256; i++) begin
         cnt = bucket[i];
         bucket[i] = sum;
         sum += cnt;
      end
      for (int e = 0; e < edges; e++) begin
         pos = bucket[mdl_weights[e]];
         bucket[mdl_weights[e]] = pos + 1;
         mdl_sorted[pos] = e;
      end
      for (int i = 0; i < nodes; i++) mdl_parent[i] = i;
      mdl_tree_count = 0;
      for (int i = 0; i < edges; i++) begin
         edge_ends(mdl_sorted[i], w, h, a, b);
         ra = find_root(a);
         rb = find_root(b);
         if (ra != rb) begin
            mdl_tree[mdl_tree_count] = {mdl_sorted[i][12:0],
                                        ({1'b0, mdl_weights[mdl_sorted[i]]} >= mdl_threshold)};
            mdl_tree_count++;
            mdl_parent[ra] = rb;
         end
      end
      mdl_read_ptr = 0;
      mdl_built_w = w;
      mdl_built_h = h;
      mdl_built = 1'b1;
   endfunction

   function automatic void predict_load(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
      if (mdl_built) begin
         mdl_built = 1'b0;
         mdl_pixel_count = 0;
         mdl_tree_count = 0;
         mdl_read_ptr = 0;
      end
      if (mdl_pixel_count < MAX_NODES) begin
         mdl_pixels[mdl_pixel_count] = '{c2: c2, c1: c1, c0: c0};
         mdl_pixel_count++;
      end
      if (mdl_pixel_count >= clamp_size(mdl_width) * clamp_size(mdl_height)) predict_build();
   endfunction

   function automatic tree_edge_type predict_read();
      tree_edge_type r;
      int a, b;
      logic [13:0] item;
      r = '0;
      if (!mdl_built || mdl_read_ptr >= mdl_tree_count) begin
         r.exhausted = 1'b1;
      end else begin
         item = mdl_tree[mdl_read_ptr];
         mdl_read_ptr++;
         edge_ends(int'(item[13:1]), mdl_built_w, mdl_built_h, a, b);
         r.node_a = a[11:0];
         r.node_b = b[11:0];
         r.weight = mdl_weights[item[13:1]];
         r.cut = item[0];
      end
      return r;
   endfunction

   task automatic drop_request();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      drop_request();
      while (edges_due.size() != 0) @(posedge clock);
      while (!req_ready) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, int value);
      wait_quiet();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[8:0];
      case (idx)
         CSR_IMAGE_WIDTH: begin
            mdl_width = value[6:0];
         end
         CSR_IMAGE_HEIGHT: begin
            mdl_height = value[6:0];
         end
         CSR_COLOR_MODE: begin
            mdl_color = value[0];
         end
         default: begin
            mdl_threshold = value[8:0];
         end
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_request(logic mode, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                               bit typed, tree_edge_type typed_edge);
      tree_edge_type r;
      if (accepted_count < 400) begin
         send_idle_pct = 20;
         recv_idle_pct = 64;
      end else if (accepted_count < 800) begin
         send_idle_pct = 64;
         recv_idle_pct = 20;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_pixel_c0 <= c0;
      req_pixel_c1 <= c1;
      req_pixel_c2 <= c2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted_count++;
      if (mode) begin
         r = predict_read();
         edges_due.push_back(typed ? typed_edge : r);
         read_count++;
      end else begin
         predict_load(c0, c1, c2);
      end
   endtask

   task automatic add_row(step_kind_type kind, int a, int b, int c, bit typed);
      stim_row_type row;
      row.kind = kind;
      row.a = a;
      row.b = b;
      row.c = c;
      row.typed = typed;
      row.typed_edge = '0;
      row.typed_edge.exhausted = typed;
      directed.push_back(row);
   endtask

   always @(posedge clock) begin
      tree_edge_type got;
      tree_edge_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_node_a, rsp_node_b, rsp_weight, rsp_cut, rsp_exhausted};
            if (edges_due.size() == 0) begin
               $display("%0t: unexpected result a=%0d b=%0d w=%0d cut=%0b exh=%0b", $time,
                        got.node_a, got.node_b, got.weight, got.cut, got.exhausted);
               fail_count++;
            end else begin
               want = edges_due.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected a=%0d b=%0d w=%0d cut=%0b exh=%0b", $time,
                           want.node_a, want.node_b, want.weight, want.cut, want.exhausted);
                  $display("%0t:          actual a=%0d b=%0d w=%0d cut=%0b exh=%0b", $time,
                           got.node_a, got.node_b, got.weight, got.cut, got.exhausted);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int w, h, nodes, style, base, nreads;
      logic [7:0] p0, p1, p2;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_pixel_c0 = '0;
      req_pixel_c1 = '0;
      req_pixel_c2 = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      accepted_count = 0;
      random_count = 0;
      frame_count = 0;
      read_count = 0;
      send_idle_pct = 20;
      recv_idle_pct = 64;
      mdl_width = 7'd64;
      mdl_height = 7'd64;
      mdl_color = 1'b0;
      mdl_threshold = 9'd256;
      for (int i = 0; i < MAX_NODES; i++) begin
         mdl_pixels[i] = '0;
         mdl_parent[i] = i;
      end
      mdl_pixel_count = 0;
      mdl_tree_count = 0;
      mdl_read_ptr = 0;
      mdl_built = 1'b0;
      mdl_built_w = 2;
      mdl_built_h = 2;

      add_row(STEP_READ, 0, 0, 0, 1);
      add_row(STEP_CSR, CSR_IMAGE_WIDTH, 0, 0, 0);
      add_row(STEP_CSR, CSR_IMAGE_HEIGHT, 1, 0, 0);
      add_row(STEP_CSR, CSR_COLOR_MODE, 1, 0, 0);
      add_row(STEP_CSR, CSR_SEGMENT_THRESHOLD, 0, 0, 0);
      add_row(STEP_LOAD, 0, 0, 0, 0);
      add_row(STEP_LOAD, 255, 255, 255, 0);
      add_row(STEP_LOAD, 0, 255, 0, 0);
      add_row(STEP_LOAD, 255, 0, 10, 0);
      add_row(STEP_READ, 0, 0, 0, 0);
      add_row(STEP_READ, 0, 0, 0, 0);
      add_row(STEP_READ, 0, 0, 0, 0);
      add_row(STEP_READ, 0, 0, 0, 1);
      add_row(STEP_CSR, CSR_SEGMENT_THRESHOLD, 511, 0, 0);
      add_row(STEP_READ, 0, 0, 0, 1);
      add_row(STEP_CSR, CSR_IMAGE_WIDTH, 3, 0, 0);
      add_row(STEP_CSR, CSR_IMAGE_HEIGHT, 3, 0, 0);
      add_row(STEP_CSR, CSR_COLOR_MODE, 0, 0, 0);
      add_row(STEP_LOAD, 7, 200, 13, 0);
      add_row(STEP_READ, 0, 0, 0, 1);
      add_row(STEP_LOAD, 9, 1, 2, 0);
      add_row(STEP_LOAD, 7, 3, 4, 0);
      add_row(STEP_LOAD, 250, 5, 6, 0);
      add_row(STEP_LOAD, 128, 7, 8, 0);
      add_row(STEP_CSR, CSR_IMAGE_WIDTH, 2, 0, 0);
      add_row(STEP_CSR, CSR_IMAGE_HEIGHT, 2, 0, 0);
      add_row(STEP_LOAD, 1, 255, 255, 0);
      add_row(STEP_READ, 0, 0, 0, 0);
      add_row(STEP_READ, 0, 0, 0, 0);
      add_row(STEP_READ, 0, 0, 0, 0);
      add_row(STEP_READ, 0, 0, 0, 1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         case (directed[i].kind)
            STEP_CSR: begin
               write_csr(directed[i].a[1:0], directed[i].b);
            end
            STEP_LOAD: begin
               send_request(1'b0, directed[i].a[7:0], directed[i].b[7:0], directed[i].c[7:0],
                            1'b0, '0);
            end
            default: begin
               send_request(1'b1, 8'd0, 8'd0, 8'd0, directed[i].typed, directed[i].typed_edge);
            end
         endcase
      end

      while (random_count < RANDOM_GOAL) begin
         style = $urandom_range(19);
         if (style == 0) begin
            w = 64;
            h = 2;
         end else if (style == 1) begin
            w = 2;
            h = 64;
         end else if (style == 2) begin
            w = $urandom_range(65, 127);
            h = $urandom_range(0, 1);
         end else if (style == 3) begin
            w = $urandom_range(0, 1);
            h = $urandom_range(2, 9);
         end else begin
            w = $urandom_range(2, 9);
            h = $urandom_range(2, 9);
         end
         write_csr(CSR_IMAGE_WIDTH, w);
         write_csr(CSR_IMAGE_HEIGHT, h);
         write_csr(CSR_COLOR_MODE, $urandom_range(1));
         case ($urandom_range(3))
            0: write_csr(CSR_SEGMENT_THRESHOLD, 0);
            1: write_csr(CSR_SEGMENT_THRESHOLD, $urandom_range(256, 511));
            default: write_csr(CSR_SEGMENT_THRESHOLD, $urandom_range(0, 300));
         endcase
         nodes = clamp_size(w[6:0]) * clamp_size(h[6:0]);
         base = $urandom_range(255);
         style = $urandom_range(3);
         for (int n = 0; n < nodes; n++) begin
            if ($urandom_range(19) == 0) begin
               send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
               random_count++;
            end
            if (style == 0) begin
               p0 = 8'($urandom);
               p1 = 8'($urandom);
               p2 = 8'($urandom);
            end else if (style == 3) begin
               p0 = base[7:0];
               p1 = base[7:0];
               p2 = 8'd255 - base[7:0];
            end else begin
               p0 = 8'(base + int'($urandom_range(7)));
               p1 = 8'(base - int'($urandom_range(15)));
               p2 = 8'($urandom_range(3) << 6);
            end
            send_request(1'b0, p0, p1, p2, 1'b0, '0);
            random_count++;
         end
         nreads = nodes - 1 + $urandom_range(2);
         if ($urandom_range(7) == 0) nreads = $urandom_range(nodes);
         for (int n = 0; n < nreads; n++) begin
            send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
            random_count++;
         end
         frame_count++;
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests, %0d random frames and %0d tree edge reads.",
               accepted_count, frame_count, read_count);
      $display("Sizes from 2x2 to 64x2 and 2x64, clamped sizes, gray and color, cut thresholds.");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
